@@ design/apsd_pkg.sv @@
// Shared types, register codes and color helpers for the attribute pixel scan-out decoder.
// Used by attribute_pixel_scanout_decoder. No other dependencies.
package apsd_pkg;

  localparam int MaxColumns = 256;
  localparam int MaxRows    = 128;

  localparam int ColW  = $clog2(MaxColumns);      // column counter
  localparam int RowW  = $clog2(MaxRows);         // row counter
  localparam int AddrW = 15;
  localparam int XW    = 11;
  localparam int YW    = 10;
  localparam int RgbW  = 24;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 10;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] RegWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] RegScale  = 2'd2;

  localparam logic [9:0] WidthMin  = 10'd128;
  localparam logic [9:0] WidthMax  = 10'(2 * MaxColumns);
  localparam logic [8:0] HeightMin = 9'd64;
  localparam logic [8:0] HeightMax = 9'(2 * MaxRows);

  localparam logic [9:0] WidthReset  = 10'd512;
  localparam logic [8:0] HeightReset = 9'd256;
  localparam logic [1:0] ScaleReset  = 2'd1;

  typedef logic [5:0]      color6_t;
  typedef logic [RgbW-1:0] rgb_t;

  typedef struct packed {
    logic [AddrW-1:0] memory_address;
    logic [XW-1:0]    screen_x;
    logic [YW-1:0]    screen_y;
    rgb_t             color_top_left;
    rgb_t             color_top_right;
    rgb_t             color_bottom_left;
    rgb_t             color_bottom_right;
    logic             end_of_frame;
  } cell_t;

  function automatic color6_t text_palette(input logic [2:0] sel);
    color6_t c;
    case (sel)
      3'd0:    c = 6'h2A;
      3'd1:    c = 6'h06;
      3'd2:    c = 6'h08;
      3'd3:    c = 6'h0A;
      3'd4:    c = 6'h20;
      3'd5:    c = 6'h38;
      3'd6:    c = 6'h3C;
      3'd7:    c = 6'h3F;
      default: c = 6'h00;
    endcase
    return c;
  endfunction

  // Each 2-bit channel times 0x55 is the channel repeated four times
  function automatic rgb_t expand_color(input color6_t c);
    return {{4{c[5:4]}}, {4{c[3:2]}}, {4{c[1:0]}}};
  endfunction

endpackage

@@ design/attribute_pixel_scanout_decoder.sv @@
// Top level of the attribute pixel scan-out decoder: raster counters, cell color decode,
// output register with skid word. Depends on apsd_pkg.
//
//   channel | direction | handshake          | word
//   in_     | in        | in_valid/in_stall   | pixel_byte
//   out_    | out       | out_valid/out_stall | address, screen position, 4 colors, eof
//   cfg_    | in        | cfg_valid/cfg_ready | register index, data
//
// One cell per cycle while in_stall is low; an accepted word goes to the output register,
// or to the skid register while the output is stalled; the output register is the single stage.
// Reset (synchronous, rst_n low) clears counters, background and valid flags, and loads
// the register defaults. A stalled output holds; one more word lands in the skid
// register, after which in_stall is raised until the output moves again.
module attribute_pixel_scanout_decoder (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         in_pixel_byte,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [apsd_pkg::AddrW-1:0]         out_memory_address,
  output logic [apsd_pkg::XW-1:0]            out_screen_x,
  output logic [apsd_pkg::YW-1:0]            out_screen_y,
  output logic [apsd_pkg::RgbW-1:0]          out_color_top_left,
  output logic [apsd_pkg::RgbW-1:0]          out_color_top_right,
  output logic [apsd_pkg::RgbW-1:0]          out_color_bottom_left,
  output logic [apsd_pkg::RgbW-1:0]          out_color_bottom_right,
  output logic                               out_end_of_frame,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [apsd_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [apsd_pkg::CfgDataW-1:0]      cfg_data
);

  logic [9:0]                 width_r;
  logic [8:0]                 height_r;
  logic [1:0]                 scale_r;
  logic [apsd_pkg::ColW-1:0]  col_r, col_nxt;
  logic [apsd_pkg::RowW-1:0]  row_r, row_nxt;
  apsd_pkg::color6_t          bg_r, bg_nxt;

  logic                       out_valid_r, skid_valid_r;
  apsd_pkg::cell_t            out_r, skid_r, dec_word;

  logic in_fire, out_pop, cfg_fire;
  logic row_end, frame_end;
  apsd_pkg::rgb_t fg_rgb, bg_rgb, flat_rgb;
  logic [apsd_pkg::ColW+1:0] col_scaled;
  logic [apsd_pkg::RowW+1:0] row_scaled;

  assign in_stall  = skid_valid_r;
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid & ~skid_valid_r;
  assign out_pop   = out_valid_r & ~out_stall;
  assign cfg_fire  = cfg_valid & cfg_ready;

  // ---- cell decode ----
  always_comb begin
    fg_rgb   = apsd_pkg::expand_color(apsd_pkg::text_palette(in_pixel_byte[6:4]));
    bg_rgb   = apsd_pkg::expand_color(bg_r);
    flat_rgb = apsd_pkg::expand_color(in_pixel_byte[5:0]);

    col_scaled = (apsd_pkg::ColW+2)'(col_r) * (apsd_pkg::ColW+2)'(scale_r);
    row_scaled = (apsd_pkg::RowW+2)'(row_r) * (apsd_pkg::RowW+2)'(scale_r);

    // Shrunk geometry mid-row: anything at or past the last column ends the row
    row_end   = ({2'b0, col_r} + 10'd1) >= {1'b0, width_r[9:1]};
    frame_end = row_end && (({1'b0, row_r} + 8'd1) >= height_r[8:1]);

    dec_word.memory_address = apsd_pkg::AddrW'({row_r, col_r});
    dec_word.screen_x       = apsd_pkg::XW'({col_scaled, 1'b0});
    dec_word.screen_y       = apsd_pkg::YW'({row_scaled, 1'b0});
    dec_word.end_of_frame   = frame_end;

    bg_nxt = bg_r;
    if (in_pixel_byte[7]) begin
      dec_word.color_top_left     = in_pixel_byte[3] ? fg_rgb : bg_rgb;
      dec_word.color_top_right    = in_pixel_byte[2] ? fg_rgb : bg_rgb;
      dec_word.color_bottom_left  = in_pixel_byte[1] ? fg_rgb : bg_rgb;
      dec_word.color_bottom_right = in_pixel_byte[0] ? fg_rgb : bg_rgb;
    end else begin
      dec_word.color_top_left     = flat_rgb;
      dec_word.color_top_right    = flat_rgb;
      dec_word.color_bottom_left  = flat_rgb;
      dec_word.color_bottom_right = flat_rgb;
      if (in_pixel_byte[6]) begin
        bg_nxt = in_pixel_byte[5:0];
      end
    end

    if (!row_end) begin
      col_nxt = col_r + 1'b1;
      row_nxt = row_r;
    end else begin
      col_nxt = '0;
      row_nxt = frame_end ? '0 : row_r + 1'b1;
    end
  end

  // ---- state and configuration ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= apsd_pkg::WidthReset;
      height_r <= apsd_pkg::HeightReset;
      scale_r  <= apsd_pkg::ScaleReset;
      col_r    <= '0;
      row_r    <= '0;
      bg_r     <= '0;
    end else begin
      if (cfg_fire) begin
        case (cfg_index)
          apsd_pkg::RegWidth: begin
            if (cfg_data >= apsd_pkg::WidthMin && cfg_data <= apsd_pkg::WidthMax) begin
              width_r <= cfg_data;
            end
          end
          apsd_pkg::RegHeight: begin
            if (cfg_data[8:0] >= apsd_pkg::HeightMin && cfg_data[8:0] <= apsd_pkg::HeightMax)
            begin
              height_r <= cfg_data[8:0];
            end
          end
          apsd_pkg::RegScale: begin
            if (cfg_data[1:0] != 2'd0) begin
              scale_r <= cfg_data[1:0];
            end
          end
          default: ;  // drop writes to unknown registers
        endcase
      end
      if (in_fire) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
        bg_r  <= bg_nxt;
      end
    end
  end

  // ---- output register and skid word ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_pop) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (in_fire) begin
      if (!out_valid_r || out_pop) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_pop) begin
        out_r <= skid_r;
      end
    end else if (in_fire) begin
      if (!out_valid_r || out_pop) begin
        out_r <= dec_word;
      end else begin
        skid_r <= dec_word;
      end
    end
  end

  assign out_valid              = out_valid_r;
  assign out_memory_address     = out_r.memory_address;
  assign out_screen_x           = out_r.screen_x;
  assign out_screen_y           = out_r.screen_y;
  assign out_color_top_left     = out_r.color_top_left;
  assign out_color_top_right    = out_r.color_top_right;
  assign out_color_bottom_left  = out_r.color_bottom_left;
  assign out_color_bottom_right = out_r.color_bottom_right;
  assign out_end_of_frame       = out_r.end_of_frame;

endmodule

@@ design/apsd_checker.sv @@
// Port-level checks for attribute_pixel_scanout_decoder, attached by bind.
// Depends on apsd_pkg for port widths.
module apsd_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [apsd_pkg::AddrW-1:0]    out_memory_address,
  input logic [apsd_pkg::XW-1:0]       out_screen_x,
  input logic [apsd_pkg::YW-1:0]       out_screen_y
);

  // A waiting output word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("output word withdrawn while stalled");

  // Input backpressure only starts behind a stalled output word
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("in_stall raised without a stalled output");

  // First column of a row sits at the left edge
  a_left_edge: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_memory_address[7:0] == 8'd0 |-> out_screen_x == '0)
    else $error("column zero with nonzero screen_x");

  // First row of a frame sits at the top edge
  a_top_edge: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_memory_address[14:8] == 7'd0 |-> out_screen_y == '0)
    else $error("row zero with nonzero screen_y");

endmodule

bind attribute_pixel_scanout_decoder apsd_checker u_apsd_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_memory_address (out_memory_address),
  .out_screen_x       (out_screen_x),
  .out_screen_y       (out_screen_y)
);

@@ bench/attribute_pixel_scanout_decoder_test.sv @@
// Self-checking bench for attribute_pixel_scanout_decoder: random byte stream, register
// changes between phases, stalls on both channels, cell-by-cell compare against a predictor.
// Depends on apsd_pkg and the block's top level.
module attribute_pixel_scanout_decoder_test;

  localparam int ClockPeriod    = 12;
  localparam int ResetCycles    = 9;
  localparam int RunLimitCycles = 400000;
  localparam int MaxReported    = 10;
  localparam int HoldOffCycles  = 300;
  localparam int TailCycles     = 4;
  localparam int TextBit        = 7;
  localparam int LatchBit       = 6;
  localparam int TargetPixels   = 1050;

  localparam logic [apsd_pkg::CfgIdxW-1:0] RegUnused = 2'd3;

  localparam apsd_pkg::color6_t PaletteColors [8] = '{
    6'h2A, 6'h06, 6'h08, 6'h0A, 6'h20, 6'h38, 6'h3C, 6'h3F
  };

  // Extremes, both cell kinds, every palette entry, latching and non-latching color bytes
  localparam logic [7:0] DirectedBytes [20] = '{
    8'h00, 8'hFF, 8'h7F, 8'h80, 8'h8F, 8'h95, 8'hA6, 8'hB3, 8'hCA, 8'hDC,
    8'hE9, 8'hF0, 8'h40, 8'h88, 8'h3F, 8'h15, 8'h2A, 8'h55, 8'hF7, 8'h01
  };

  class cell_predictor;
    apsd_pkg::cell_t           pending_cells[$];
    logic [9:0]                width_reg;
    logic [8:0]                height_reg;
    logic [1:0]                scale_reg;
    logic [apsd_pkg::ColW-1:0] column;
    logic [apsd_pkg::RowW-1:0] row;
    apsd_pkg::color6_t         background;
    int                        failures;

    function new();
      width_reg    = apsd_pkg::WidthReset;
      height_reg   = apsd_pkg::HeightReset;
      scale_reg    = apsd_pkg::ScaleReset;
      column       = '0;
      row          = '0;
      background   = '0;
      failures     = 0;
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= MaxReported) begin
        $display("%s", msg);
      end
    endfunction

    function apsd_pkg::rgb_t widen(apsd_pkg::color6_t c);
      return {8'(c[5:4]) * 8'h55, 8'(c[3:2]) * 8'h55, 8'(c[1:0]) * 8'h55};
    endfunction

    // Out-of-range values and unknown indexes leave the registers alone
    function void write_register(logic [apsd_pkg::CfgIdxW-1:0] idx,
                                 logic [apsd_pkg::CfgDataW-1:0] data);
      case (idx)
        apsd_pkg::RegWidth: begin
          if (data >= apsd_pkg::WidthMin && data <= apsd_pkg::WidthMax) width_reg = data;
        end
        apsd_pkg::RegHeight: begin
          if (data[8:0] >= apsd_pkg::HeightMin && data[8:0] <= apsd_pkg::HeightMax)
            height_reg = data[8:0];
        end
        apsd_pkg::RegScale: begin
          if (data[1:0] != 2'd0) scale_reg = data[1:0];
        end
        default: ;
      endcase
    endfunction

    function void note_pixel(logic [7:0] b);
      apsd_pkg::cell_t c;
      apsd_pkg::rgb_t  fg;
      apsd_pkg::rgb_t  bg;
      int              cols;
      int              rows;
      cols = int'(width_reg) / 2;
      rows = int'(height_reg) / 2;
      if (b[TextBit]) begin
        fg = widen(PaletteColors[b[6:4]]);
        bg = widen(background);
        c.color_top_left     = b[3] ? fg : bg;
        c.color_top_right    = b[2] ? fg : bg;
        c.color_bottom_left  = b[1] ? fg : bg;
        c.color_bottom_right = b[0] ? fg : bg;
      end else begin
        if (b[LatchBit]) background = b[5:0];
        fg = widen(b[5:0]);
        c.color_top_left     = fg;
        c.color_top_right    = fg;
        c.color_bottom_left  = fg;
        c.color_bottom_right = fg;
      end
      c.memory_address = apsd_pkg::AddrW'(int'(row) * 256 + int'(column));
      c.screen_x       = apsd_pkg::XW'(int'(column) * 2 * int'(scale_reg));
      c.screen_y       = apsd_pkg::YW'(int'(row) * 2 * int'(scale_reg));
      c.end_of_frame   = 1'b0;
      // A shrunk geometry ends the row or frame as soon as the counter is at or past the limit
      if (int'(column) + 1 >= cols) begin
        column = '0;
        if (int'(row) + 1 >= rows) begin
          row = '0;
          c.end_of_frame = 1'b1;
        end else begin
          row = row + 1'b1;
        end
      end else begin
        column = column + 1'b1;
      end
      pending_cells.push_back(c);
    endfunction

    function void check_cell(apsd_pkg::cell_t seen);
      apsd_pkg::cell_t want;
      if (pending_cells.size() == 0) begin
        flag($sformatf("output word with nothing pending: %p", seen));
        return;
      end
      want = pending_cells.pop_front();
      if (seen !== want) begin
        flag($sformatf("output word mismatch: expected %p, got %p", want, seen));
      end
    endfunction
  endclass

  logic                          clk           = 1'b0;
  logic                          rst_n         = 1'b0;
  logic                          in_valid      = 1'b0;
  logic                          in_stall;
  logic [7:0]                    in_pixel_byte = 8'h00;
  logic                          out_valid;
  logic                          out_stall     = 1'b0;
  logic [apsd_pkg::AddrW-1:0]    out_memory_address;
  logic [apsd_pkg::XW-1:0]       out_screen_x;
  logic [apsd_pkg::YW-1:0]       out_screen_y;
  logic [apsd_pkg::RgbW-1:0]     out_color_top_left;
  logic [apsd_pkg::RgbW-1:0]     out_color_top_right;
  logic [apsd_pkg::RgbW-1:0]     out_color_bottom_left;
  logic [apsd_pkg::RgbW-1:0]     out_color_bottom_right;
  logic                          out_end_of_frame;
  logic                          cfg_valid     = 1'b0;
  logic                          cfg_ready;
  logic [apsd_pkg::CfgIdxW-1:0]  cfg_index     = '0;
  logic [apsd_pkg::CfgDataW-1:0] cfg_data      = '0;

  cell_predictor   cells = new();
  apsd_pkg::cell_t seen_cell;
  int              pixels_sent = 0;
  int              hold_left   = 0;

  attribute_pixel_scanout_decoder u_top (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_pixel_byte          (in_pixel_byte),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_memory_address     (out_memory_address),
    .out_screen_x           (out_screen_x),
    .out_screen_y           (out_screen_y),
    .out_color_top_left     (out_color_top_left),
    .out_color_top_right    (out_color_top_right),
    .out_color_bottom_left  (out_color_bottom_left),
    .out_color_bottom_right (out_color_bottom_right),
    .out_end_of_frame       (out_end_of_frame),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data)
  );

  always #(ClockPeriod / 2) clk = ~clk;

  assign seen_cell = {out_memory_address, out_screen_x, out_screen_y, out_color_top_left,
                      out_color_top_right, out_color_bottom_left, out_color_bottom_right,
                      out_end_of_frame};

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) cells.check_cell(seen_cell);
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(16, 40);
  endfunction

  // Output side: random stall runs, quiet stretches, and the long hold-off on request
  initial begin
    int   r;
    int   run_left;
    logic run_stall;
    run_left  = 0;
    run_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        if (run_left == 0) begin
          r = $urandom_range(0, 9);
          if (r < 3) begin
            run_stall = 1'b0;
            run_left  = $urandom_range(20, 80);
          end else if (r < 6) begin
            run_stall = 1'b0;
            run_left  = $urandom_range(1, 3);
          end else begin
            run_stall = 1'b1;
            run_left  = pick_gap() + 1;
          end
        end
        out_stall <= run_stall;
        run_left--;
      end
    end
  end

  task automatic send_pixel(input logic [7:0] b, input bit gappy);
    int gap;
    gap = gappy ? pick_gap() : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    in_pixel_byte <= b;
    do @(posedge clk); while (in_stall);
    cells.note_pixel(b);
    pixels_sent++;
  endtask

  task automatic feed_random(input int count, input bit allow_gaps);
    bit gappy;
    gappy = allow_gaps && ($urandom_range(0, 3) != 0);
    repeat (count) send_pixel(8'($urandom_range(0, 255)), gappy);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (cells.pending_cells.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_register(input logic [apsd_pkg::CfgIdxW-1:0] idx,
                              input logic [apsd_pkg::CfgDataW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cells.write_register(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    #(ClockPeriod * RunLimitCycles);
    $display("attribute_pixel_scanout_decoder test failed");
    $finish;
  end

  initial begin
    int w;
    int h;
    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (DirectedBytes[i]) send_pixel(DirectedBytes[i], 1'b1);
    @(negedge clk);
    in_valid <= 1'b0;
    wait_drained();

    // Rejected writes: out of range after masking, and the unused index
    set_register(apsd_pkg::RegWidth, 10'd0);
    set_register(apsd_pkg::RegWidth, 10'd127);
    set_register(apsd_pkg::RegWidth, 10'd513);
    set_register(apsd_pkg::RegWidth, 10'h3FF);
    set_register(apsd_pkg::RegHeight, 10'd0);
    set_register(apsd_pkg::RegHeight, 10'd63);
    set_register(apsd_pkg::RegHeight, 10'd257);
    set_register(apsd_pkg::RegHeight, 10'h3FF);
    set_register(apsd_pkg::RegScale, 10'h000);
    set_register(apsd_pkg::RegScale, 10'h3FC);
    set_register(RegUnused, 10'h3FF);
    set_register(apsd_pkg::RegWidth, 10'd200);
    set_register(apsd_pkg::RegHeight, 10'd100);
    set_register(apsd_pkg::RegScale, 10'd2);
    feed_random(120, 1'b1);
    wait_drained();

    // Full width at triple scale; upper data bits are dropped by the height and scale masks
    set_register(apsd_pkg::RegWidth, 10'h200);
    set_register(apsd_pkg::RegHeight, 10'h2C0);
    set_register(apsd_pkg::RegScale, 10'h3FF);
    @(posedge clk);
    hold_left = HoldOffCycles;
    feed_random(300, 1'b0);
    wait_drained();

    // Narrow the row while the column sits far past the new end
    set_register(apsd_pkg::RegWidth, 10'd128);
    set_register(apsd_pkg::RegHeight, 10'h100);
    set_register(apsd_pkg::RegScale, 10'd1);
    feed_random(150, 1'b1);

    while (pixels_sent < TargetPixels) begin
      wait_drained();
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(130, 180) : 128 + $urandom_range(0, 1);
      // Drop the height to the current row or under it to close the frame early
      h = (cells.row >= 31) ? 64 + $urandom_range(0, 1) : $urandom_range(64, 256);
      set_register(apsd_pkg::RegWidth, 10'(w));
      set_register(apsd_pkg::RegHeight, 10'(h));
      set_register(apsd_pkg::RegScale, 10'($urandom_range(1, 3)));
      if ($urandom_range(0, 3) == 0) set_register(RegUnused, 10'($urandom));
      feed_random($urandom_range(100, 250), 1'b1);
    end

    wait_drained();
    repeat (TailCycles) @(posedge clk);
    if (cells.failures == 0) begin
      $display("attribute_pixel_scanout_decoder test passed");
    end else begin
      $display("attribute_pixel_scanout_decoder test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/apsd_pkg.sv
design/attribute_pixel_scanout_decoder.sv
design/apsd_checker.sv
bench/attribute_pixel_scanout_decoder_test.sv
